// ===== rtl/rpit_pkg.sv =====
package rpit_pkg;

    localparam int COORD_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MD_ADD = 2'd0,
        MD_REF = 2'd1,
        MD_REL = 2'd2,
        MD_QRY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_EXIST = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // word handed from cell to cell
    typedef struct packed {
        logic                valid;
        t_mode               mode;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [INDEX_W-1:0]  idx;
        logic                done;
        t_status             status;
        logic [INDEX_W-1:0]  res_index;
        logic [COUNT_W-1:0]  cnt;
        logic                vis;
    } t_word;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
    endfunction

endpackage

// ===== rtl/rpit_cell.sv =====
module rpit_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpit_pkg::t_word i_word,
    output rpit_pkg::t_word o_word
);

    localparam logic [rpit_pkg::INDEX_W-1:0] MY_INDEX = rpit_pkg::INDEX_W'(CELL_INDEX);

    rpit_pkg::t_word                  r_word, n_word;
    logic                             r_used, n_used;
    logic [rpit_pkg::COORD_W-1:0]     r_x, n_x;
    logic [rpit_pkg::COORD_W-1:0]     r_y, n_y;
    logic [rpit_pkg::COUNT_W-1:0]     r_cnt, n_cnt;
    logic                             r_vis, n_vis;
    logic                             idx_hit;

    assign idx_hit = (32'(i_word.idx) == 32'(CELL_INDEX));

    always_comb begin
        n_word = i_word;
        n_used = r_used;
        n_x    = r_x;
        n_y    = r_y;
        n_cnt  = r_cnt;
        n_vis  = r_vis;
        if (i_word.valid && !i_word.done) begin
            case (i_word.mode)
                rpit_pkg::MD_ADD: begin
                    if (r_used && r_x == i_word.x && r_y == i_word.y) begin
                        n_cnt            = rpit_pkg::bump(r_cnt);
                        n_word.done      = 1'b1;
                        n_word.status    = rpit_pkg::ST_EXIST;
                        n_word.res_index = MY_INDEX;
                        n_word.cnt       = n_cnt;
                        n_word.vis       = r_vis;
                    end else if (!r_used) begin
                        // first free slot: append
                        n_used           = 1'b1;
                        n_x              = i_word.x;
                        n_y              = i_word.y;
                        n_cnt            = rpit_pkg::COUNT_W'(1);
                        n_vis            = 1'b1;
                        n_word.done      = 1'b1;
                        n_word.status    = rpit_pkg::ST_NEW;
                        n_word.res_index = MY_INDEX;
                        n_word.cnt       = n_cnt;
                        n_word.vis       = 1'b1;
                    end
                end
                rpit_pkg::MD_REF: begin
                    if (idx_hit) begin
                        n_cnt       = rpit_pkg::bump(r_cnt);
                        n_vis       = 1'b1;
                        n_word.done = 1'b1;
                        n_word.cnt  = n_cnt;
                        n_word.vis  = 1'b1;
                    end
                end
                rpit_pkg::MD_REL: begin
                    if (idx_hit) begin
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - rpit_pkg::COUNT_W'(1);
                        end
                        if (n_cnt == '0) begin
                            n_x   = '0;
                            n_y   = '0;
                            n_vis = 1'b0;
                        end
                        n_word.done = 1'b1;
                        n_word.cnt  = n_cnt;
                        n_word.vis  = n_vis;
                    end
                end
                rpit_pkg::MD_QRY: begin
                    if (idx_hit) begin
                        n_word.done = 1'b1;
                        n_word.cnt  = r_cnt;
                        n_word.vis  = r_vis;
                    end
                end
                default: begin
                    n_word = i_word;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
            r_used       <= 1'b0;
            r_cnt        <= '0;
            r_vis        <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
            r_used       <= n_used;
            r_cnt        <= n_cnt;
            r_vis        <= n_vis;
        end
        r_word.mode      <= n_word.mode;
        r_word.x         <= n_word.x;
        r_word.y         <= n_word.y;
        r_word.idx       <= n_word.idx;
        r_word.done      <= n_word.done;
        r_word.status    <= n_word.status;
        r_word.res_index <= n_word.res_index;
        r_word.cnt       <= n_word.cnt;
        r_word.vis       <= n_word.vis;
        r_x              <= n_x;
        r_y              <= n_y;
    end

    assign o_word = r_word;

endmodule

// ===== rtl/refcounted_point_intern_table.sv =====
// channel   direction  handshake             fields
// command   in         start & !busy         i_mode i_point_x i_point_y i_entry_index
// result    out        o_valid (one cycle)   o_result_index o_status o_ref_count o_visible
//
// A command word enters the row of TABLE_DEPTH cells and moves one cell per cycle.
// Its result leaves from the last cell; every cell holds the word in a register.
// Words follow in order, so a new command is taken in every cycle that busy is low.
// busy is high only during reset; reset clears all counts, flags and words in flight.
// The receiver cannot stall; each result is shown for one cycle.
module refcounted_point_intern_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic signed [rpit_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [rpit_pkg::COORD_W-1:0] i_point_y,
    input  logic [rpit_pkg::INDEX_W-1:0]       i_entry_index,
    output logic                               o_valid,
    output logic [rpit_pkg::INDEX_W-1:0]       o_result_index,
    output logic [1:0]                         o_status,
    output logic [rpit_pkg::COUNT_W-1:0]       o_ref_count,
    output logic                               o_visible
);

    rpit_pkg::t_word chain [TABLE_DEPTH+1];
    rpit_pkg::t_word tail;
    logic            accept;

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    always_comb begin
        chain[0].valid     = accept;
        chain[0].mode      = rpit_pkg::t_mode'(i_mode);
        chain[0].x         = $unsigned(i_point_x);
        chain[0].y         = $unsigned(i_point_y);
        chain[0].idx       = i_entry_index;
        chain[0].done      = 1'b0;
        chain[0].status    = rpit_pkg::ST_EXIST;
        chain[0].res_index = i_entry_index;
        chain[0].cnt       = '0;
        chain[0].vis       = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            rpit_cell #(
                .CELL_INDEX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_word  (chain[g]),
                .o_word  (chain[g+1])
            );
        end
    endgenerate

    // add that found neither a match nor a free slot
    always_comb begin
        tail = chain[TABLE_DEPTH];
        if (tail.mode == rpit_pkg::MD_ADD && !tail.done) begin
            tail.status    = rpit_pkg::ST_FULL;
            tail.res_index = '0;
            tail.cnt       = '0;
            tail.vis       = 1'b0;
        end
    end

    assign o_valid        = tail.valid;
    assign o_result_index = tail.res_index;
    assign o_status       = tail.status;
    assign o_ref_count    = tail.cnt;
    assign o_visible      = tail.vis;

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, TABLE_DEPTH))
        else $error("result without matching command");

    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rpit_pkg::ST_NEW) |-> (o_ref_count == 1 && o_visible))
        else $error("new entry not created with count one");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rpit_pkg::ST_FULL)
            |-> (o_ref_count == 0 && !o_visible && o_result_index == 0))
        else $error("full result carries entry data");

endmodule
